@@ hdl/i2rt_pkg.sv @@
// shared types, constants and codes for the signed integer to radix text block
// no dependencies; every other file refers to this package by scoped names
package i2rt_pkg;

    localparam int VALUE_W            = 32;   // input value width
    localparam int CHAR_W             = 8;    // one text character
    localparam int SLOTS              = 16;   // alphabet slots held by the registers
    localparam int RADIX_W            = 5;    // radix 2..16, 0 marks an invalid alphabet
    localparam int DIGIT_W            = 4;    // digit index into the alphabet
    localparam int MAX_DIGITS         = 32;   // radix 2 of 2^31 needs 32 digits
    localparam int DEPTH_W            = 6;    // holds 0..MAX_DIGITS
    localparam int BITS_PER_STEP      = 8;    // dividend bits retired per divider cycle
    localparam int DIV_STEPS          = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W             = 2;    // counts the divider steps of a digit
    localparam int ADDR_W             = 4;    // two 64-bit registers at 0x0 and 0x8
    localparam int REG_W              = 64;
    localparam int MAX_BASE_CHARS_DEF = 16;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    // register select, taken from paddr bit 3
    localparam logic REG_ALPHA_LOW  = 1'b0;
    localparam logic REG_ALPHA_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef logic [SLOTS-1:0][CHAR_W-1:0] alpha_t;

    typedef struct packed {
        logic load;       // capture sign and magnitude of the accepted value
        logic div_step;   // retire BITS_PER_STEP dividend bits
        logic div_last;   // final step of a digit: push the remainder
        logic out_sign;   // load '-' into the output register
        logic out_digit;  // pop a digit into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic radix_ok;       // configured alphabet is usable
        logic neg;            // value being printed is negative
        logic quo_zero_next;  // quotient after this step is zero
        logic out_free;       // output register takes a character this cycle
        logic last_digit;     // one digit left on the stack
    } dp_stat_t;

endpackage

@@ hdl/signed_integer_to_radix_text.sv @@
// top level: signed 32-bit value to text in a configured digit alphabet
// depends on i2rt_pkg, i2rt_cfg, i2rt_dp, i2rt_ctrl
//
// usage
//   program the alphabet over the apb port: 0x0 holds characters 0..7, 0x8 holds
//   characters 8..15, one byte each, lowest byte first. the alphabet ends at the
//   first zero byte; its length is the radix. fewer than two characters, a '+' or
//   '-', or a repeated character makes it invalid, and values then give no text.
//   each value taken on the s_ channel leaves as characters on the m_ channel:
//   a '-' for a negative value, then the digits most significant first, with
//   m_tlast on the final digit. -2^31 prints as '-' and the digits of 2^31.
// timing
//   one value at a time. the divider retires 8 dividend bits a cycle; all digits
//   are divided out before the first character shows, then one character a cycle
//   while m_tready is high. a value is dropped in the start state, after the
//   transaction, when the alphabet is invalid.
// reset and stall
//   reset clears both alphabet registers (an invalid alphabet) and the control
//   state; m_tvalid drops. when the receiver stalls the output register holds
//   its character and the block waits; s_tready comes back as soon as the last
//   digit sits in the output register.
module signed_integer_to_radix_text #(
    parameter int MAX_BASE_CHARS = i2rt_pkg::MAX_BASE_CHARS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic signed [i2rt_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [i2rt_pkg::CHAR_W-1:0]          m_tdata,   // [7:0] character
    output logic                                 m_tlast,   // last character of a value
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [i2rt_pkg::ADDR_W-1:0]          paddr,
    input  logic [i2rt_pkg::REG_W-1:0]           pwdata,
    output logic [i2rt_pkg::REG_W-1:0]           prdata,
    output logic                                 pready
);

    i2rt_pkg::alpha_t              alpha;
    logic [i2rt_pkg::RADIX_W-1:0]  radix;
    i2rt_pkg::dp_cmd_t             cmd;
    i2rt_pkg::dp_stat_t            stat;

    // registers and the registered alphabet check
    i2rt_cfg #(
        .MAX_BASE_CHARS(MAX_BASE_CHARS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .alpha   (alpha),
        .radix   (radix)
    );

    // sequencing: accept, check, divide per digit, sign, emit
    i2rt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // magnitude, divider, digit stack and output register
    i2rt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_value  (s_tdata),
        .alpha    (alpha),
        .radix    (radix),
        .cmd      (cmd),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_char   (m_tdata),
        .m_last   (m_tlast),
        .stat     (stat)
    );

endmodule

@@ hdl/i2rt_cfg.sv @@
// configuration registers (apb-style) and alphabet check for the radix text block
// depends on i2rt_pkg
module i2rt_cfg #(
    parameter int MAX_BASE_CHARS = i2rt_pkg::MAX_BASE_CHARS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2rt_pkg::ADDR_W-1:0]       paddr,
    input  logic [i2rt_pkg::REG_W-1:0]        pwdata,
    output logic [i2rt_pkg::REG_W-1:0]        prdata,
    output logic                              pready,
    output i2rt_pkg::alpha_t                  alpha,
    output logic [i2rt_pkg::RADIX_W-1:0]      radix
);

    localparam int LIMIT = (MAX_BASE_CHARS > i2rt_pkg::SLOTS) ? i2rt_pkg::SLOTS : MAX_BASE_CHARS;

    logic [i2rt_pkg::REG_W-1:0]   alpha_low_reg;
    logic [i2rt_pkg::REG_W-1:0]   alpha_high_reg;
    logic [i2rt_pkg::RADIX_W-1:0] radix_reg;
    logic [i2rt_pkg::RADIX_W-1:0] radix_next;
    logic [i2rt_pkg::SLOTS-1:0]   in_alpha;
    logic [i2rt_pkg::RADIX_W-1:0] len;
    logic                         run;
    logic                         bad_char;
    logic                         dup;
    logic                         wr_en;
    logic                         reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3];
    assign pready  = 1'b1;
    assign prdata  = (reg_sel == i2rt_pkg::REG_ALPHA_HIGH) ? alpha_high_reg : alpha_low_reg;
    assign alpha   = {alpha_high_reg, alpha_low_reg};
    assign radix   = radix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            radix_reg      <= '0;
        end else begin
            if (wr_en && reg_sel == i2rt_pkg::REG_ALPHA_LOW) begin
                alpha_low_reg <= pwdata;
            end
            if (wr_en && reg_sel == i2rt_pkg::REG_ALPHA_HIGH) begin
                alpha_high_reg <= pwdata;
            end
            radix_reg <= radix_next;
        end
    end

    // alphabet ends at the first zero byte or at the slot limit
    always_comb begin
        in_alpha = '0;
        run      = 1'b1;
        len      = '0;
        bad_char = 1'b0;
        dup      = 1'b0;
        for (int k = 0; k < i2rt_pkg::SLOTS; k++) begin
            run         = run && (k < LIMIT) && (alpha[k] != '0);
            in_alpha[k] = run;
            if (run) begin
                len = len + i2rt_pkg::RADIX_W'(1);
            end
            if (run && (alpha[k] == i2rt_pkg::CHAR_PLUS || alpha[k] == i2rt_pkg::CHAR_MINUS)) begin
                bad_char = 1'b1;
            end
        end
        for (int i = 0; i < i2rt_pkg::SLOTS; i++) begin
            for (int j = i + 1; j < i2rt_pkg::SLOTS; j++) begin
                if (in_alpha[j] && alpha[i] == alpha[j]) begin
                    dup = 1'b1;
                end
            end
        end
        radix_next = (len < i2rt_pkg::RADIX_W'(2) || bad_char || dup) ? '0 : len;
    end

endmodule

@@ hdl/i2rt_dp.sv @@
// datapath: magnitude, shared small-radix divider, digit stack, output register
// depends on i2rt_pkg; driven by i2rt_ctrl commands
module i2rt_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [i2rt_pkg::VALUE_W-1:0]  s_value,
    input  i2rt_pkg::alpha_t                     alpha,
    input  logic [i2rt_pkg::RADIX_W-1:0]         radix,
    input  i2rt_pkg::dp_cmd_t                    cmd,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [i2rt_pkg::CHAR_W-1:0]          m_char,
    output logic                                 m_last,
    output i2rt_pkg::dp_stat_t                   stat
);

    logic                                                   neg_reg;
    logic [i2rt_pkg::VALUE_W-1:0]                           div_reg;
    logic [i2rt_pkg::DIGIT_W-1:0]                           rem_reg;
    logic [i2rt_pkg::MAX_DIGITS-1:0][i2rt_pkg::DIGIT_W-1:0] stack_reg;
    logic [i2rt_pkg::DEPTH_W-1:0]                           nd_reg;
    logic                                                   m_valid_reg;
    logic [i2rt_pkg::CHAR_W-1:0]                            m_char_reg;
    logic                                                   m_last_reg;

    logic [i2rt_pkg::VALUE_W-1:0]       raw;
    logic [i2rt_pkg::VALUE_W-1:0]       mag_in;
    logic [i2rt_pkg::RADIX_W-1:0]       part_rem;
    logic [i2rt_pkg::BITS_PER_STEP-1:0] qbits;
    logic [i2rt_pkg::DIGIT_W-1:0]       rem_step;
    logic [i2rt_pkg::VALUE_W-1:0]       quo_step;
    logic                               out_free;

    assign raw    = $unsigned(s_value);
    assign mag_in = raw[i2rt_pkg::VALUE_W-1] ? (~raw + i2rt_pkg::VALUE_W'(1)) : raw;

    // long division, one dividend bit per inner step, remainder stays below radix
    always_comb begin
        part_rem = i2rt_pkg::RADIX_W'(rem_reg);
        qbits    = '0;
        for (int b = 0; b < i2rt_pkg::BITS_PER_STEP; b++) begin
            part_rem = {part_rem[i2rt_pkg::RADIX_W-2:0], div_reg[i2rt_pkg::VALUE_W-1-b]};
            if (part_rem >= radix) begin
                part_rem = part_rem - radix;
                qbits[i2rt_pkg::BITS_PER_STEP-1-b] = 1'b1;
            end
        end
        rem_step = part_rem[i2rt_pkg::DIGIT_W-1:0];
        quo_step = {div_reg[i2rt_pkg::VALUE_W-i2rt_pkg::BITS_PER_STEP-1:0], qbits};
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                nd_reg <= '0;
            end else if (cmd.div_step && cmd.div_last) begin
                nd_reg <= nd_reg + i2rt_pkg::DEPTH_W'(1);
            end else if (cmd.out_digit) begin
                nd_reg <= nd_reg - i2rt_pkg::DEPTH_W'(1);
            end
            if (cmd.out_sign || cmd.out_digit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg <= raw[i2rt_pkg::VALUE_W-1];
            div_reg <= mag_in;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            div_reg <= quo_step;
            rem_reg <= cmd.div_last ? '0 : rem_step;
        end
        // top of the stack is entry 0
        if (cmd.div_step && cmd.div_last) begin
            stack_reg <= {stack_reg[i2rt_pkg::MAX_DIGITS-2:0], rem_step};
        end else if (cmd.out_digit) begin
            stack_reg <= {i2rt_pkg::DIGIT_W'(0), stack_reg[i2rt_pkg::MAX_DIGITS-1:1]};
        end
        if (cmd.out_sign) begin
            m_char_reg <= i2rt_pkg::CHAR_MINUS;
            m_last_reg <= 1'b0;
        end else if (cmd.out_digit) begin
            m_char_reg <= alpha[stack_reg[0]];
            m_last_reg <= (nd_reg == i2rt_pkg::DEPTH_W'(1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_char   = m_char_reg;
    assign m_last   = m_last_reg;

    assign stat.radix_ok      = (radix != '0);
    assign stat.neg           = neg_reg;
    assign stat.quo_zero_next = (quo_step == '0);
    assign stat.out_free      = out_free;
    assign stat.last_digit    = (nd_reg == i2rt_pkg::DEPTH_W'(1));

endmodule

@@ hdl/i2rt_ctrl.sv @@
// controller state machine for the radix text block
// depends on i2rt_pkg; commands i2rt_dp and reads its status
module i2rt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  i2rt_pkg::dp_stat_t stat,
    output i2rt_pkg::dp_cmd_t  cmd
);

    localparam logic [i2rt_pkg::STEP_W-1:0] LAST_STEP = i2rt_pkg::STEP_W'(i2rt_pkg::DIV_STEPS - 1);

    i2rt_pkg::state_t              state_reg;
    i2rt_pkg::state_t              state_next;
    logic [i2rt_pkg::STEP_W-1:0]   step_reg;
    logic [i2rt_pkg::STEP_W-1:0]   step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2rt_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = '0;
        case (state_reg)
            i2rt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = i2rt_pkg::ST_START;
                end
            end
            i2rt_pkg::ST_START: begin
                state_next = stat.radix_ok ? i2rt_pkg::ST_DIV : i2rt_pkg::ST_IDLE;
            end
            i2rt_pkg::ST_DIV: begin
                step_next = (step_reg == LAST_STEP) ? '0 : step_reg + i2rt_pkg::STEP_W'(1);
                if (step_reg == LAST_STEP && stat.quo_zero_next) begin
                    state_next = stat.neg ? i2rt_pkg::ST_SIGN : i2rt_pkg::ST_EMIT;
                end
            end
            i2rt_pkg::ST_SIGN: begin
                if (stat.out_free) begin
                    state_next = i2rt_pkg::ST_EMIT;
                end
            end
            i2rt_pkg::ST_EMIT: begin
                if (stat.out_free && stat.last_digit) begin
                    state_next = i2rt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2rt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            i2rt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            i2rt_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_last = (step_reg == LAST_STEP);
            end
            i2rt_pkg::ST_SIGN: begin
                cmd.out_sign = stat.out_free;
            end
            i2rt_pkg::ST_EMIT: begin
                cmd.out_digit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hdl/i2rt_checker.sv @@
// port-level checks for the radix text block, bound to the top level
// depends on i2rt_pkg and signed_integer_to_radix_text
module i2rt_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic signed [i2rt_pkg::VALUE_W-1:0]  s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [i2rt_pkg::CHAR_W-1:0]          m_tdata,
    input logic                                 m_tlast,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [i2rt_pkg::ADDR_W-1:0]          paddr,
    input logic [i2rt_pkg::REG_W-1:0]           pwdata,
    input logic [i2rt_pkg::REG_W-1:0]           prdata,
    input logic                                 pready
);

    // a stalled character holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output character changed");

    // one value at a time: busy right after an input transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a value is in progress");

    // a minus sign is never the last character
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == i2rt_pkg::CHAR_MINUS |-> !m_tlast)
        else $error("minus sign flagged as last");

    // when ready for a new value, any pending character closes the previous one
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("ready for input with an unfinished value pending");

endmodule

bind signed_integer_to_radix_text i2rt_checker u_i2rt_checker (.*);

@@ verif/i2rt_text_checker.sv @@
// checker for signed_integer_to_radix_text: watches the apb port and both stream channels
// predicts the characters of every accepted value and compares them in order
// depends on i2rt_pkg
module i2rt_text_checker #(
    parameter int MAX_BASE_CHARS = i2rt_pkg::MAX_BASE_CHARS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [i2rt_pkg::VALUE_W-1:0]     s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [i2rt_pkg::CHAR_W-1:0]      m_tdata,
    input  logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [i2rt_pkg::ADDR_W-1:0]      paddr,
    input  logic [i2rt_pkg::REG_W-1:0]       pwdata,
    output int                               fail_count,
    output int                               chars_pending
);

    localparam int CW         = i2rt_pkg::CHAR_W;
    localparam int SLOT_LIMIT = (MAX_BASE_CHARS > i2rt_pkg::SLOTS) ?
                                i2rt_pkg::SLOTS : MAX_BASE_CHARS;

    typedef logic [i2rt_pkg::SLOTS*CW-1:0] alpha_bits_t;

    typedef struct packed {
        logic [CW-1:0] ch;
        logic          last;
    } text_char_t;

    logic [i2rt_pkg::REG_W-1:0] alpha_low;
    logic [i2rt_pkg::REG_W-1:0] alpha_high;
    text_char_t                 text_q[$];

    // radix of the alphabet, 0 when it is unusable
    function automatic int unsigned alphabet_radix(input alpha_bits_t alpha);
        int unsigned n;
        logic [CW-1:0] c;
        bit          ended;
        n = 0;
        ended = 0;
        for (int k = 0; k < SLOT_LIMIT; k++) begin
            c = alpha[CW*k +: CW];
            if (!ended) begin
                if (c == '0)
                    ended = 1;
                else if (c == i2rt_pkg::CHAR_PLUS || c == i2rt_pkg::CHAR_MINUS)
                    return 0;
                else
                    n++;
            end
        end
        if (n < 2)
            return 0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (alpha[CW*i +: CW] == alpha[CW*j +: CW])
                    return 0;
        return n;
    endfunction

    function automatic void predict_text(input logic [i2rt_pkg::VALUE_W-1:0] raw);
        alpha_bits_t                   alpha;
        int unsigned                   radix;
        logic [i2rt_pkg::VALUE_W-1:0]  mag;
        logic [CW-1:0]                 digits[i2rt_pkg::MAX_DIGITS];
        int                            nd;
        logic                          neg;
        alpha = {alpha_high, alpha_low};
        radix = alphabet_radix(alpha);
        if (radix == 0)
            return;
        neg = raw[i2rt_pkg::VALUE_W-1];
        // two's complement negation also gives 2^31 for the most negative value
        mag = neg ? (32'd0 - raw) : raw;
        nd = 0;
        do begin
            digits[nd] = alpha[CW*(mag % radix) +: CW];
            nd++;
            mag = mag / radix;
        end while (mag != 0 && nd < i2rt_pkg::MAX_DIGITS);
        if (neg)
            text_q.push_back('{ch: i2rt_pkg::CHAR_MINUS, last: 1'b0});
        while (nd > 0) begin
            nd--;
            text_q.push_back('{ch: digits[nd], last: (nd == 0)});
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            alpha_low     = '0;
            alpha_high    = '0;
            text_q.delete();
            fail_count    = 0;
            chars_pending = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[3] == i2rt_pkg::REG_ALPHA_LOW)
                    alpha_low = pwdata;
                else
                    alpha_high = pwdata;
            end
            // results first: a value accepted at this edge comes after them
            if (m_tvalid && m_tready) begin
                if (text_q.size() == 0) begin
                    report_mismatch("character with no value pending", m_tdata, '0);
                end else begin
                    want = text_q.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch("character", m_tdata, want.ch);
                    if (m_tlast !== want.last)
                        report_mismatch("last flag", CW'(m_tlast), CW'(want.last));
                end
            end
            if (s_tvalid && s_tready)
                predict_text(s_tdata);
            chars_pending = text_q.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// top of the signed_integer_to_radix_text regression: clock, reset, apb and stream stimulus
// depends on i2rt_pkg, the block under test and i2rt_text_checker
module tb_top;

    localparam int CW           = i2rt_pkg::CHAR_W;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off to back up the input
    localparam int SETTLE_CYCLES = 8;     // also covers a dropped value, which leaves the block through the start state
    localparam int DRAIN_CYCLES = 200;    // outlasts the worst value, which is in radix 2
    localparam int QUIET_LIMIT  = 2000;   // cycles with no transaction before giving up

    localparam logic [i2rt_pkg::ADDR_W-1:0] ADDR_ALPHA_LOW  = {i2rt_pkg::REG_ALPHA_LOW, 3'b000};
    localparam logic [i2rt_pkg::ADDR_W-1:0] ADDR_ALPHA_HIGH = {i2rt_pkg::REG_ALPHA_HIGH, 3'b000};

    typedef logic [i2rt_pkg::SLOTS*CW-1:0] alpha_bits_t;

    typedef enum int {
        MODE_STEADY,
        MODE_SEND_GAPS,
        MODE_RECV_STALLS,
        MODE_BOTH
    } idle_mode_t;

    // ways to spoil an otherwise good alphabet
    typedef enum int {
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_REPEAT
    } flaw_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [i2rt_pkg::VALUE_W-1:0]     s_tdata;      // [31:0] value
    logic                             m_tvalid;
    logic                             m_tready;
    logic [CW-1:0]                    m_tdata;      // [7:0] character
    logic                             m_tlast;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [i2rt_pkg::ADDR_W-1:0]      paddr;
    logic [i2rt_pkg::REG_W-1:0]       pwdata;
    logic [i2rt_pkg::REG_W-1:0]       prdata;
    logic                             pready;

    int fail_count;
    int chars_pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;

    always #2 aclk = ~aclk;

    signed_integer_to_radix_text uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    i2rt_text_checker u_text_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    // receiver: random stalls, or a long hold-off when the stimulus asks for one
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: any transaction on either channel or the apb port resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("signed_integer_to_radix_text regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_mode(input idle_mode_t mode);
        case (mode)
            MODE_STEADY: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            MODE_SEND_GAPS: begin
                send_idle_pct  = 51;
                recv_stall_pct = 0;
            end
            MODE_RECV_STALLS: begin
                send_idle_pct  = 0;
                recv_stall_pct = 51;
            end
            default: begin
                send_idle_pct  = 8;
                recv_stall_pct = 8;
            end
        endcase
    endtask

    // apb write: setup cycle then access cycle, entered and left at a falling edge
    task automatic write_reg(input logic [i2rt_pkg::ADDR_W-1:0] addr,
                             input logic [i2rt_pkg::REG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_alphabet(input alpha_bits_t alpha);
        write_reg(ADDR_ALPHA_LOW, alpha[i2rt_pkg::REG_W-1:0]);
        write_reg(ADDR_ALPHA_HIGH, alpha[2*i2rt_pkg::REG_W-1:i2rt_pkg::REG_W]);
        @(negedge aclk);
    endtask

    // first character in the lowest byte, zero bytes after the text
    function automatic alpha_bits_t pack_text(input string text);
        alpha_bits_t alpha;
        alpha = '0;
        for (int k = 0; k < text.len(); k++)
            alpha[CW*k +: CW] = text[k];
        return alpha;
    endfunction

    // n distinct legal characters, a terminator when short, junk bytes behind it, one spoiled when broken
    function automatic alpha_bits_t make_alphabet(input int unsigned n, input bit broken);
        alpha_bits_t alpha;
        bit [255:0]  used;
        logic [CW-1:0] c;
        int unsigned pos;
        used = '0;
        used[0] = 1'b1;
        used[i2rt_pkg::CHAR_PLUS] = 1'b1;
        used[i2rt_pkg::CHAR_MINUS] = 1'b1;
        for (int k = 0; k < i2rt_pkg::SLOTS; k++)
            alpha[CW*k +: CW] = $urandom_range(255, 0);
        for (int k = 0; k < n; k++) begin
            do c = $urandom_range(255, 1); while (used[c]);
            used[c] = 1'b1;
            alpha[CW*k +: CW] = c;
        end
        if (n < i2rt_pkg::SLOTS)
            alpha[CW*n +: CW] = '0;
        if (broken) begin
            pos = $urandom_range(n - 1, 0);
            case (flaw_t'($urandom_range(2, 0)))
                FLAW_PLUS:  alpha[CW*pos +: CW] = i2rt_pkg::CHAR_PLUS;
                FLAW_MINUS: alpha[CW*pos +: CW] = i2rt_pkg::CHAR_MINUS;
                default:    alpha[CW*pos +: CW] = alpha[CW*((pos + 1) % n) +: CW];
            endcase
        end
        return alpha;
    endfunction

    // full-range values for four draws in ten, extremes and short texts for the rest
    function automatic logic [i2rt_pkg::VALUE_W-1:0] random_value();
        logic [i2rt_pkg::VALUE_W-1:0] v;
        case ($urandom_range(9, 0))
            0:       v = '0;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7fff_ffff;
            3:       v = '1;
            4:       v = $urandom_range(40, 0);
            5:       v = 32'd0 - $urandom_range(40, 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // offer one value; returns at the falling edge after its transaction
    task automatic send_value(input logic [i2rt_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop offering, let every predicted character arrive, then a short settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (chars_pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        alpha_bits_t alpha;
        int unsigned radix;
        int          count;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_request   = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // reset held from time zero, released at a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_mode(MODE_STEADY);

        // alphabet left at reset is empty: values are dropped
        send_value(32'd1);
        send_value(32'hffff_fffb);
        quiesce();

        // full sixteen slots with no terminator
        write_alphabet(pack_text("0123456789abcdef"));
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hffff_ffff);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        send_value(32'h1234_5678);
        quiesce();

        // radix 2: most negative value gives the longest text
        write_alphabet(pack_text("01"));
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(32'hffff_ffff);
        quiesce();

        write_alphabet(pack_text("0123456789"));
        send_value(32'd0);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        quiesce();

        // signs behind the terminator do not spoil the alphabet
        alpha = pack_text("01234");
        alpha[CW*9 +: CW] = i2rt_pkg::CHAR_MINUS;
        alpha[CW*12 +: CW] = i2rt_pkg::CHAR_PLUS;
        write_alphabet(alpha);
        send_value(32'hffff_ff85);
        quiesce();

        // unusable alphabets: one character, a plus, a minus, a repeat
        write_alphabet(pack_text("7"));
        send_value(32'd99);
        quiesce();
        write_alphabet(pack_text("01+3"));
        send_value(32'd5);
        quiesce();
        write_alphabet(pack_text("-01"));
        send_value(32'hffff_fff0);
        quiesce();
        write_alphabet(pack_text("0120"));
        send_value(32'd7);
        quiesce();

        // random part: every idling mode, radix 2, radix 16, random radixes and a bad one
        for (int m = 0; m < 4; m++) begin
            set_mode(idle_mode_t'(m));
            for (int a = 0; a < 5; a++) begin
                if (a == 0)
                    radix = 2;
                else if (a == 1)
                    radix = i2rt_pkg::SLOTS;
                else
                    radix = $urandom_range(i2rt_pkg::SLOTS - 1, 3);
                write_alphabet(make_alphabet(radix, a == 4));
                // back-pressure: receiver holds off while values keep coming
                if (m == MODE_STEADY && a == 0)
                    hold_request = HOLD_CYCLES;
                count = (a == 4) ? 4 : 14;
                repeat (count) send_value(random_value());
                quiesce();
            end
        end

        // drain: nothing expected any more, then room for stray characters
        set_mode(MODE_STEADY);
        while (chars_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0)
            $display("signed_integer_to_radix_text regression: pass");
        else
            $display("signed_integer_to_radix_text regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
hdl/i2rt_pkg.sv
hdl/i2rt_cfg.sv
hdl/i2rt_dp.sv
hdl/i2rt_ctrl.sv
hdl/signed_integer_to_radix_text.sv
hdl/i2rt_checker.sv
verif/i2rt_text_checker.sv
verif/tb_top.sv
